@@ hdl/rsz_pkg.sv @@
// Shared constants, codes and types of the bilinear image resize block.
// Depends on nothing; every other file of the block but rsz_div refers to it by scoped names.
`default_nettype none

package rsz_pkg;

  // Default sizes of the source image store and of the weight fraction.
  localparam int unsigned MaxSrcWidthDef  = 256;
  localparam int unsigned MaxSrcHeightDef = 256;
  localparam int unsigned FracBitsDef     = 16;

  // Field widths of the transactions.
  localparam int unsigned CoordW = 12;
  localparam int unsigned PixW   = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumChan = 3;

  // Destination size registers: 13 bits, saturating at 4096.
  localparam int unsigned DstW   = 13;
  localparam int unsigned DstMax = 4096;
  localparam int unsigned DstRst = 256;
  localparam int unsigned SrcRst = 256;

  // Register port geometry.
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgSrcWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDstWidth  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDstHeight = 2'd3;

  // Action codes of an input transaction.
  localparam logic ActLoad    = 1'b0;
  localparam logic ActRequest = 1'b1;

  // Bookkeeping that travels with a request down the pipeline.
  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic              in_range;
  } tag_t;

endpackage

`default_nettype wire

@@ hdl/rsz_if.sv @@
// Valid/ready channel interfaces for the input and result transactions.
// Depends on rsz_pkg for the field widths.
`default_nettype none

interface rsz_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [rsz_pkg::CoordW-1:0]   coord_x;
  logic [rsz_pkg::CoordW-1:0]   coord_y;
  logic [rsz_pkg::PixW-1:0]     pixel_in;

  modport source (output valid, action, coord_x, coord_y, pixel_in, input ready);
  modport sink   (input valid, action, coord_x, coord_y, pixel_in, output ready);
endinterface

interface rsz_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rsz_pkg::CoordW-1:0]   out_x;
  logic [rsz_pkg::CoordW-1:0]   out_y;
  logic [rsz_pkg::PixW-1:0]     pixel_out;
  logic                         in_range;

  modport source (output valid, out_x, out_y, pixel_out, in_range, input ready);
  modport sink   (input valid, out_x, out_y, pixel_out, in_range, output ready);
endinterface

`default_nettype wire

@@ hdl/rsz_div.sv @@
// Restoring divider, one quotient bit per cycle, used for the scale ratios.
// Depends on nothing outside itself.
`default_nettype none

module rsz_div #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] acc_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;

  logic [DenW:0]   rem_sh;
  logic [DenW:0]   diff;
  logic            ge;

  // One step: shift the next numerator bit into the remainder and try a subtract.
  always_comb begin
    rem_sh = {rem_q, acc_q[NumW-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = (rem_sh >= {1'b0, den_q});
  end

  // The numerator shifts out of acc while the quotient shifts in behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
      acc_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[NumW-2:0], ge};
      rem_q <= ge ? diff[DenW-1:0] : rem_sh[DenW-1:0];
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = acc_q;

endmodule

`default_nettype wire

@@ hdl/rsz_store.sv @@
// Source image store: one write port and one read port with registered read data.
// Depends on rsz_pkg for the pixel width.
`default_nettype none

module rsz_store #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [rsz_pkg::PixW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [rsz_pkg::PixW-1:0] rdata_o
);

  logic [rsz_pkg::PixW-1:0] mem [Depth];
  logic [rsz_pkg::PixW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/rsz_blend.sv @@
// Two-stage weighting of the four neighbor pixels and the result register.
// Depends on rsz_pkg and on the result channel interface rsz_rsp_if.
`default_nettype none

module rsz_blend #(
  parameter int unsigned FracBits = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [rsz_pkg::PixW-1:0] pix_a_i,
  input  logic [rsz_pkg::PixW-1:0] pix_b_i,
  input  logic [rsz_pkg::PixW-1:0] pix_c_i,
  input  logic [rsz_pkg::PixW-1:0] pix_d_i,
  input  logic [FracBits-1:0]      wx_i,
  input  logic [FracBits-1:0]      wy_i,
  input  rsz_pkg::tag_t            tag_i,
  rsz_rsp_if.source                rsp_o
);

  localparam int unsigned ChanW = rsz_pkg::ChanW;
  localparam int unsigned WW    = FracBits + 1;
  localparam int unsigned HW    = ChanW + WW;
  localparam int unsigned VW    = HW + WW;
  localparam logic [WW-1:0] One = {1'b1, {FracBits{1'b0}}};

  logic                h_v_q;
  logic [HW-1:0]       top_q [rsz_pkg::NumChan];
  logic [HW-1:0]       bot_q [rsz_pkg::NumChan];
  logic [FracBits-1:0] wy_q;
  rsz_pkg::tag_t       tag_q;

  logic                     o_v_q;
  logic [rsz_pkg::PixW-1:0] o_pix_q;
  rsz_pkg::tag_t            o_tag_q;

  logic [HW-1:0]            top_d [rsz_pkg::NumChan];
  logic [HW-1:0]            bot_d [rsz_pkg::NumChan];
  logic [rsz_pkg::PixW-1:0] pix_d;
  logic [WW-1:0]            wxc;
  logic [WW-1:0]            wxf;
  logic [WW-1:0]            wyc;
  logic [WW-1:0]            wyf;
  logic [VW-1:0]            sum;
  logic                     h_adv;

  assign h_adv      = h_v_q && (!o_v_q || rsp_o.ready);
  assign in_ready_o = !h_v_q || h_adv;

  // Horizontal pass: blend the top pair and the bottom pair along x.
  always_comb begin
    wxf = {1'b0, wx_i};
    wxc = One - wxf;
    for (int c = 0; c < rsz_pkg::NumChan; c++) begin
      top_d[c] = HW'(pix_a_i[c*ChanW +: ChanW]) * HW'(wxc)
               + HW'(pix_b_i[c*ChanW +: ChanW]) * HW'(wxf);
      bot_d[c] = HW'(pix_c_i[c*ChanW +: ChanW]) * HW'(wxc)
               + HW'(pix_d_i[c*ChanW +: ChanW]) * HW'(wxf);
    end
  end

  // Vertical pass: blend the two rows along y and truncate the fraction; an out-of-range result is zero.
  always_comb begin
    wyf   = {1'b0, wy_q};
    wyc   = One - wyf;
    pix_d = '0;
    sum   = '0;
    for (int c = 0; c < rsz_pkg::NumChan; c++) begin
      sum = VW'(top_q[c]) * VW'(wyc) + VW'(bot_q[c]) * VW'(wyf);
      pix_d[c*ChanW +: ChanW] = sum[2*FracBits +: ChanW];
    end
    if (!tag_q.in_range) begin
      pix_d = '0;
    end
  end

  // Stage registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        h_v_q <= 1'b1;
        top_q <= top_d;
        bot_q <= bot_d;
        wy_q  <= wy_i;
        tag_q <= tag_i;
      end else if (h_adv) begin
        h_v_q <= 1'b0;
      end
      if (h_adv) begin
        o_v_q   <= 1'b1;
        o_pix_q <= pix_d;
        o_tag_q <= tag_q;
      end else if (rsp_o.ready) begin
        o_v_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid     = o_v_q;
  assign rsp_o.out_x     = o_tag_q.out_x;
  assign rsp_o.out_y     = o_tag_q.out_y;
  assign rsp_o.pixel_out = o_pix_q;
  assign rsp_o.in_range  = o_tag_q.in_range;

endmodule

`default_nettype wire

@@ hdl/bilinear_image_resize_unit.sv @@
// Top level of the bilinear image resize block: registers, address pipeline, read sequencer.
// Depends on rsz_pkg, rsz_if, rsz_div, rsz_store and rsz_blend.
`default_nettype none

// Load transactions write one source pixel each and are taken one per cycle while no
// earlier request holds the read sequencer and no ratio update runs. A request
// transaction reads its four neighbor pixels through the single read port of the image
// store, one after another, then passes the hand-off and blend stages; the next item
// waits in the accept stage until its last read issues, so that port sets the rate. A
// register write starts two serial dividers for the scale ratios; until both are through,
// no input transaction is taken. The image store has no reset and no clearing pass: the
// user must load a pixel before it is read, as the block itself does not enforce this.
module bilinear_image_resize_unit #(
  parameter int unsigned MAX_SRC_WIDTH  = rsz_pkg::MaxSrcWidthDef,
  parameter int unsigned MAX_SRC_HEIGHT = rsz_pkg::MaxSrcHeightDef,
  parameter int unsigned FRAC_BITS      = rsz_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rsz_req_if.sink                   req_i,
  rsz_rsp_if.source                 rsp_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rsz_pkg::AddrW-1:0] paddr,
  input  logic [rsz_pkg::DataW-1:0] pwdata,
  output logic [rsz_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned CoordW = rsz_pkg::CoordW;
  localparam int unsigned DstW   = rsz_pkg::DstW;
  localparam int unsigned SXW    = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned SYW    = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned SWW    = $clog2(MAX_SRC_WIDTH + 1);
  localparam int unsigned SHW    = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int unsigned RXW    = SXW + FRAC_BITS;
  localparam int unsigned RYW    = SYW + FRAC_BITS;
  localparam int unsigned GXW    = RXW + CoordW;
  localparam int unsigned GYW    = RYW + CoordW;
  localparam int unsigned Depth  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned SrcWRst =
    (MAX_SRC_WIDTH > rsz_pkg::SrcRst) ? rsz_pkg::SrcRst : MAX_SRC_WIDTH;
  localparam int unsigned SrcHRst =
    (MAX_SRC_HEIGHT > rsz_pkg::SrcRst) ? rsz_pkg::SrcRst : MAX_SRC_HEIGHT;
  localparam logic [RXW-1:0] RatioXRst =
    RXW'(((64'(SrcWRst) - 64'd1) << FRAC_BITS) / (64'(rsz_pkg::DstRst) - 64'd1));
  localparam logic [RYW-1:0] RatioYRst =
    RYW'(((64'(SrcHRst) - 64'd1) << FRAC_BITS) / (64'(rsz_pkg::DstRst) - 64'd1));

  typedef enum logic [1:0] {PhA, PhB, PhC, PhD} phase_e;

  // ---------------------------------------------------------------------------
  // Configuration registers and ratio computation.
  logic [SWW-1:0]  srcw_q;
  logic [SHW-1:0]  srch_q;
  logic [DstW-1:0] dstw_q;
  logic [DstW-1:0] dsth_q;
  logic [RXW-1:0]  ratio_x_q;
  logic [RYW-1:0]  ratio_y_q;
  logic            cfg_upd_q;
  logic            run_q;

  logic            cfg_we;
  logic [8:0]      src_v;
  logic [8:0]      src_wv;
  logic [8:0]      src_hv;
  logic [DstW-1:0] dst_v;
  logic [DstW-1:0] dst_cv;
  logic            busy_x;
  logic            busy_y;
  logic [RXW-1:0]  quo_x;
  logic [RYW-1:0]  quo_y;
  logic            div_done;
  logic [SXW-1:0]  xmax;
  logic [SYW-1:0]  ymax;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  // Sizes use pwdata[8:0] (src) or [12:0] (dst); zero reads as one, sizes above the maximum saturate.
  always_comb begin
    src_v  = pwdata[8:0];
    dst_v  = pwdata[DstW-1:0];
    src_wv = (src_v == '0) ? 9'd1 :
             ((32'(src_v) > MAX_SRC_WIDTH) ? 9'(MAX_SRC_WIDTH) : src_v);
    src_hv = (src_v == '0) ? 9'd1 :
             ((32'(src_v) > MAX_SRC_HEIGHT) ? 9'(MAX_SRC_HEIGHT) : src_v);
    dst_cv = (dst_v == '0) ? DstW'(1) :
             ((32'(dst_v) > rsz_pkg::DstMax) ? DstW'(rsz_pkg::DstMax) : dst_v);
  end

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      rsz_pkg::CfgSrcWidth:  prdata = rsz_pkg::DataW'(srcw_q);
      rsz_pkg::CfgSrcHeight: prdata = rsz_pkg::DataW'(srch_q);
      rsz_pkg::CfgDstWidth:  prdata = rsz_pkg::DataW'(dstw_q);
      rsz_pkg::CfgDstHeight: prdata = rsz_pkg::DataW'(dsth_q);
      default:               prdata = '0;
    endcase
  end

  assign xmax     = SXW'(srcw_q - SWW'(1));
  assign ymax     = SYW'(srch_q - SHW'(1));
  assign div_done = run_q && !busy_x && !busy_y;

  rsz_div #(.NumW(RXW), .DenW(CoordW)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_upd_q),
    .num_i   ({xmax, {FRAC_BITS{1'b0}}}),
    .den_i   (CoordW'(dstw_q - DstW'(1))),
    .busy_o  (busy_x),
    .quo_o   (quo_x)
  );

  rsz_div #(.NumW(RYW), .DenW(CoordW)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_upd_q),
    .num_i   ({ymax, {FRAC_BITS{1'b0}}}),
    .den_i   (CoordW'(dsth_q - DstW'(1))),
    .busy_o  (busy_y),
    .quo_o   (quo_y)
  );

  // Register writes, then a ratio update once both dividers are through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srcw_q    <= SWW'(SrcWRst);
      srch_q    <= SHW'(SrcHRst);
      dstw_q    <= DstW'(rsz_pkg::DstRst);
      dsth_q    <= DstW'(rsz_pkg::DstRst);
      ratio_x_q <= RatioXRst;
      ratio_y_q <= RatioYRst;
      cfg_upd_q <= 1'b0;
      run_q     <= 1'b0;
    end else begin
      cfg_upd_q <= cfg_we;
      if (cfg_we) begin
        case (paddr[3:2])
          rsz_pkg::CfgSrcWidth:  srcw_q <= SWW'(src_wv);
          rsz_pkg::CfgSrcHeight: srch_q <= SHW'(src_hv);
          rsz_pkg::CfgDstWidth:  dstw_q <= dst_cv;
          rsz_pkg::CfgDstHeight: dsth_q <= dst_cv;
          default: ;
        endcase
      end
      if (cfg_upd_q) begin
        run_q <= 1'b1;
      end else if (div_done) begin
        run_q <= 1'b0;
      end
      if (div_done) begin
        ratio_x_q <= (dstw_q == DstW'(1)) ? '0 : quo_x;
        ratio_y_q <= (dsth_q == DstW'(1)) ? '0 : quo_y;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: position products for requests, store address for loads.
  logic                     m_v_q;
  logic                     m_load_q;
  logic [CoordW-1:0]        m_x_q;
  logic [CoordW-1:0]        m_y_q;
  logic [rsz_pkg::PixW-1:0] m_pix_q;
  logic                     m_inr_q;
  logic [GXW-1:0]           m_gx_q;
  logic [GYW-1:0]           m_gy_q;

  logic s1_free;
  logic m_adv;
  logic req_acc;

  assign m_adv       = m_v_q && s1_free;
  assign req_i.ready = !cfg_upd_q && !run_q && (!m_v_q || m_adv);
  assign req_acc     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (req_acc) begin
      m_v_q    <= 1'b1;
      m_load_q <= (req_i.action == rsz_pkg::ActLoad);
      m_x_q    <= req_i.coord_x;
      m_y_q    <= req_i.coord_y;
      m_pix_q  <= req_i.pixel_in;
      m_inr_q  <= ({1'b0, req_i.coord_x} < dstw_q) && ({1'b0, req_i.coord_y} < dsth_q);
      m_gx_q   <= GXW'(ratio_x_q) * GXW'(req_i.coord_x);
      m_gy_q   <= GYW'(ratio_y_q) * GYW'(req_i.coord_y);
    end else if (m_adv) begin
      m_v_q <= 1'b0;
    end
  end

  // A load writes when it leaves, once no earlier request still has reads to issue.
  logic          st_we;
  logic [AW-1:0] st_waddr;

  assign st_we = m_adv && m_load_q && (32'(m_x_q) < MAX_SRC_WIDTH)
                 && (32'(m_y_q) < MAX_SRC_HEIGHT);
  assign st_waddr = AW'(m_y_q[SYW-1:0]) * AW'(MAX_SRC_WIDTH) + AW'(m_x_q[SXW-1:0]);

  // Corner coordinates and weights, limited to the source size.
  logic [GXW-FRAC_BITS-1:0] gxi;
  logic [GYW-FRAC_BITS-1:0] gyi;
  logic [SXW-1:0]           c_xl;
  logic [SXW-1:0]           c_xh;
  logic [SYW-1:0]           c_yl;
  logic [SYW-1:0]           c_yh;
  logic [FRAC_BITS-1:0]     c_wx;
  logic [FRAC_BITS-1:0]     c_wy;

  always_comb begin
    gxi  = m_gx_q[GXW-1:FRAC_BITS];
    gyi  = m_gy_q[GYW-1:FRAC_BITS];
    c_wx = m_gx_q[FRAC_BITS-1:0];
    c_wy = m_gy_q[FRAC_BITS-1:0];
    c_xl = (gxi > (GXW-FRAC_BITS)'(xmax)) ? xmax : SXW'(gxi);
    c_yl = (gyi > (GYW-FRAC_BITS)'(ymax)) ? ymax : SYW'(gyi);
    c_xh = ((c_wx != '0) && (c_xl != xmax)) ? c_xl + SXW'(1) : c_xl;
    c_yh = ((c_wy != '0) && (c_yl != ymax)) ? c_yl + SYW'(1) : c_yl;
  end

  // ---------------------------------------------------------------------------
  // Read sequencer: four reads per request, one per cycle while the hand-off stage can take the last one.
  logic                     s1_v_q;
  phase_e                   ph_q;
  logic [SXW-1:0]           s1_xl_q;
  logic [SXW-1:0]           s1_xh_q;
  logic [SYW-1:0]           s1_yl_q;
  logic [SYW-1:0]           s1_yh_q;
  logic [FRAC_BITS-1:0]     s1_wx_q;
  logic [FRAC_BITS-1:0]     s1_wy_q;
  rsz_pkg::tag_t            s1_tag_q;
  logic [rsz_pkg::PixW-1:0] s1_pa_q;
  logic [rsz_pkg::PixW-1:0] s1_pb_q;

  logic                     d_free;
  logic                     st_re;
  logic [AW-1:0]            st_raddr;
  logic [rsz_pkg::PixW-1:0] st_rdata;
  logic [SXW-1:0]           rd_x;
  logic [SYW-1:0]           rd_y;
  logic                     s1_load;
  logic                     d_go;

  assign st_re   = s1_v_q && ((ph_q != PhD) || d_free);
  assign s1_free = !s1_v_q || ((ph_q == PhD) && d_free);
  assign s1_load = m_adv && !m_load_q;
  assign d_go    = st_re && (ph_q == PhD);

  always_comb begin
    case (ph_q)
      PhA:     begin rd_x = s1_xl_q; rd_y = s1_yl_q; end
      PhB:     begin rd_x = s1_xh_q; rd_y = s1_yl_q; end
      PhC:     begin rd_x = s1_xl_q; rd_y = s1_yh_q; end
      PhD:     begin rd_x = s1_xh_q; rd_y = s1_yh_q; end
      default: begin rd_x = s1_xl_q; rd_y = s1_yl_q; end
    endcase
    st_raddr = AW'(rd_y) * AW'(MAX_SRC_WIDTH) + AW'(rd_x);
  end

  // Each read's data is registered in the store; the previous read is captured as the next issues.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      ph_q   <= PhA;
    end else begin
      if (st_re) begin
        case (ph_q)
          PhA:     ph_q <= PhB;
          PhB:     begin ph_q <= PhC; s1_pa_q <= st_rdata; end
          PhC:     begin ph_q <= PhD; s1_pb_q <= st_rdata; end
          PhD:     s1_v_q <= 1'b0;
          default: ph_q <= PhA;
        endcase
      end
      if (s1_load) begin
        s1_v_q   <= 1'b1;
        ph_q     <= PhA;
        s1_xl_q  <= c_xl;
        s1_xh_q  <= c_xh;
        s1_yl_q  <= c_yl;
        s1_yh_q  <= c_yh;
        s1_wx_q  <= c_wx;
        s1_wy_q  <= c_wy;
        s1_tag_q <= '{out_x: m_x_q, out_y: m_y_q, in_range: m_inr_q};
      end
    end
  end

  rsz_store #(.Depth(Depth), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (m_pix_q),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // ---------------------------------------------------------------------------
  // Hand-off stage: collects the last neighbor as it arrives from the store.
  logic                     d_v_q;
  logic                     d_fresh_q;
  logic [rsz_pkg::PixW-1:0] d_pa_q;
  logic [rsz_pkg::PixW-1:0] d_pb_q;
  logic [rsz_pkg::PixW-1:0] d_pc_q;
  logic [rsz_pkg::PixW-1:0] d_pd_q;
  logic [FRAC_BITS-1:0]     d_wx_q;
  logic [FRAC_BITS-1:0]     d_wy_q;
  rsz_pkg::tag_t            d_tag_q;

  logic                     bl_ready;
  logic                     d_adv;
  logic [rsz_pkg::PixW-1:0] d_pd;

  assign d_adv  = d_v_q && bl_ready;
  assign d_free = !d_v_q || d_adv;
  assign d_pd   = d_fresh_q ? st_rdata : d_pd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q     <= 1'b0;
      d_fresh_q <= 1'b0;
    end else begin
      d_fresh_q <= d_go;
      if (d_fresh_q) begin
        d_pd_q <= st_rdata;
      end
      if (d_go) begin
        d_v_q   <= 1'b1;
        d_pa_q  <= s1_pa_q;
        d_pb_q  <= s1_pb_q;
        d_pc_q  <= st_rdata;
        d_wx_q  <= s1_wx_q;
        d_wy_q  <= s1_wy_q;
        d_tag_q <= s1_tag_q;
      end else if (d_adv) begin
        d_v_q <= 1'b0;
      end
    end
  end

  rsz_blend #(.FracBits(FRAC_BITS)) u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (d_v_q),
    .in_ready_o (bl_ready),
    .pix_a_i    (d_pa_q),
    .pix_b_i    (d_pb_q),
    .pix_c_i    (d_pc_q),
    .pix_d_i    (d_pd),
    .wx_i       (d_wx_q),
    .wy_i       (d_wy_q),
    .tag_i      (d_tag_q),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

@@ hdl/rsz_checker.sv @@
// Port-level assertions of the bilinear image resize block and their bind.
// Depends on rsz_pkg and on the top level bilinear_image_resize_unit.
`default_nettype none

module rsz_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       req_ready,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic [rsz_pkg::CoordW-1:0] rsp_x,
  input wire logic [rsz_pkg::CoordW-1:0] rsp_y,
  input wire logic [rsz_pkg::PixW-1:0]   rsp_pixel,
  input wire logic                       rsp_in_range,
  input wire logic                       cfg_wr
);

  // A result that waits keeps offering itself.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result transaction withdrawn before it was taken");

  // A result that waits keeps its payload.
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_y)
      && $stable(rsp_pixel) && $stable(rsp_in_range))
    else $error("result payload changed while stalled");

  // A request outside the destination returns a black pixel.
  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_in_range |-> rsp_pixel == '0)
    else $error("out-of-range result carries a nonzero pixel");

  // After a register write, input is held off as the ratio recomputation starts.
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> !req_ready ##1 !req_ready)
    else $error("input taken while the scale ratios were being recomputed");

endmodule

bind bilinear_image_resize_unit rsz_checker u_rsz_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_ready    (req_i.ready),
  .rsp_valid    (rsp_o.valid),
  .rsp_ready    (rsp_o.ready),
  .rsp_x        (rsp_o.out_x),
  .rsp_y        (rsp_o.out_y),
  .rsp_pixel    (rsp_o.pixel_out),
  .rsp_in_range (rsp_o.in_range),
  .cfg_wr       (psel && penable && pwrite)
);

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for bilinear_image_resize_unit: loads source pixels, requests
// resized pixels and compares each result with a local bilinear predictor.
// Depends on rsz_pkg, rsz_if and the block's RTL; it reads no files.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordW   = rsz_pkg::CoordW;
  localparam int unsigned PixW     = rsz_pkg::PixW;
  localparam int unsigned FracBits = rsz_pkg::FracBitsDef;
  localparam int unsigned StoreW   = rsz_pkg::MaxSrcWidthDef;
  localparam int unsigned StoreH   = rsz_pkg::MaxSrcHeightDef;

  typedef struct packed {
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [PixW-1:0]   pixel_out;
    logic              in_range;
  } resized_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [rsz_pkg::AddrW-1:0] paddr;
  logic [rsz_pkg::DataW-1:0] pwdata;
  logic [rsz_pkg::DataW-1:0] prdata;
  logic pready;

  rsz_req_if req ();
  rsz_rsp_if rsp ();

  bilinear_image_resize_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 0;
  end

  // Predictor state: the image store, which entries were loaded, sizes and ratios.
  logic [PixW-1:0] image_store [StoreW*StoreH];
  bit              pixel_loaded [StoreW*StoreH];
  int unsigned     src_w, src_h, dst_w, dst_h;
  longint unsigned scale_x, scale_y;
  resized_pixel_t  expected_pixels [$];

  int errors;
  int n_loads, n_requests, n_results, n_reg_writes;
  int send_idle_pct, recv_idle_pct;
  int hold_token, hold_len;

  function automatic longint unsigned scale_ratio(int unsigned src, int unsigned dst);
    if (dst <= 1) return 0;
    return (longint'(src - 1) << FracBits) / longint'(dst - 1);
  endfunction

  function automatic int unsigned sat_size(int unsigned v, int unsigned max);
    if (v == 0) return 1;
    return (v > max) ? max : v;
  endfunction

  function automatic void apply_register(logic [rsz_pkg::CfgIdxW-1:0] idx,
                                         logic [rsz_pkg::DataW-1:0] val);
    int unsigned v;
    v = val & 32'h1FFF;
    case (idx)
      rsz_pkg::CfgSrcWidth:  src_w = sat_size(v & 32'h1FF, StoreW);
      rsz_pkg::CfgSrcHeight: src_h = sat_size(v & 32'h1FF, StoreH);
      rsz_pkg::CfgDstWidth:  dst_w = sat_size(v, rsz_pkg::DstMax);
      default:               dst_h = sat_size(v, rsz_pkg::DstMax);
    endcase
    scale_x = scale_ratio(src_w, dst_w);
    scale_y = scale_ratio(src_h, dst_h);
  endfunction

  // Source corners and fractional weights of one output coordinate.
  function automatic void find_corners(input logic [CoordW-1:0] cx, cy,
                                       output int unsigned xl, xh, yl, yh,
                                       output longint unsigned wx, wy);
    longint unsigned gx, gy;
    gx = scale_x * cx;
    gy = scale_y * cy;
    wx = gx & ((64'd1 << FracBits) - 1);
    wy = gy & ((64'd1 << FracBits) - 1);
    xl = gx >> FracBits;
    yl = gy >> FracBits;
    if (xl > src_w - 1) xl = src_w - 1;
    if (yl > src_h - 1) yl = src_h - 1;
    xh = xl + (wx != 0);
    yh = yl + (wy != 0);
    if (xh > src_w - 1) xh = src_w - 1;
    if (yh > src_h - 1) yh = src_h - 1;
  endfunction

  function automatic logic [7:0] blend_channel(logic [PixW-1:0] a, b, c, d, int sh,
                                               longint unsigned wx, wy);
    longint unsigned one, s;
    one = 64'd1 << FracBits;
    s = longint'(a[sh+:8]) * (one - wx) * (one - wy)
      + longint'(b[sh+:8]) * wx * (one - wy)
      + longint'(c[sh+:8]) * (one - wx) * wy
      + longint'(d[sh+:8]) * wx * wy;
    s = s >> (2 * FracBits);
    return (s > 255) ? 8'hFF : s[7:0];
  endfunction

  function automatic resized_pixel_t resize_pixel(logic [CoordW-1:0] cx, cy);
    resized_pixel_t r;
    int unsigned xl, xh, yl, yh, ch;
    longint unsigned wx, wy;
    logic [PixW-1:0] a, b, c, d;
    r = '0;
    r.out_x = cx;
    r.out_y = cy;
    if (cx >= dst_w || cy >= dst_h) return r;
    find_corners(cx, cy, xl, xh, yl, yh, wx, wy);
    a = image_store[yl*StoreW + xl];
    b = image_store[yl*StoreW + xh];
    c = image_store[yh*StoreW + xl];
    d = image_store[yh*StoreW + xh];
    for (ch = 0; ch < 3; ch++) r.pixel_out[8*ch+:8] = blend_channel(a, b, c, d, 8*ch, wx, wy);
    r.in_range = 1'b1;
    return r;
  endfunction

  // Offer one item; on acceptance update the store or queue the expected pixel.
  // Valid is left high so a following item can go out back to back.
  task automatic send_item(logic act, logic [CoordW-1:0] x, y, logic [PixW-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid    <= 1'b1;
    req.action   <= act;
    req.coord_x  <= x;
    req.coord_y  <= y;
    req.pixel_in <= pix;
    do @(posedge clk_i); while (!req.ready);
    if (act == rsz_pkg::ActLoad) begin
      n_loads++;
      if (x < StoreW && y < StoreH) begin
        image_store[y*StoreW + x]  = pix;
        pixel_loaded[y*StoreW + x] = 1'b1;
      end
    end else begin
      n_requests++;
      expected_pixels.push_back(resize_pixel(x, y));
    end
  endtask

  task automatic load_if_missing(int unsigned x, int unsigned y);
    if (!pixel_loaded[y*StoreW + x]) send_item(rsz_pkg::ActLoad, x, y, $urandom);
  endtask

  // A request inside the destination first loads any neighbor pixel that was never written.
  task automatic send_request(logic [CoordW-1:0] x, y);
    int unsigned xl, xh, yl, yh;
    longint unsigned wx, wy;
    if (x < dst_w && y < dst_h) begin
      find_corners(x, y, xl, xh, yl, yh, wx, wy);
      load_if_missing(xl, yl);
      load_if_missing(xh, yl);
      load_if_missing(xl, yh);
      load_if_missing(xh, yh);
    end
    send_item(rsz_pkg::ActRequest, x, y, $urandom);
  endtask

  // Wait for every queued result; loads give none, so allow the pipeline to empty too.
  task automatic wait_results_drained();
    req.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_register(logic [rsz_pkg::CfgIdxW-1:0] idx,
                                logic [rsz_pkg::DataW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    apply_register(idx, val);
    n_reg_writes++;
  endtask

  task automatic set_sizes(logic [31:0] sw, sh, dw, dh);
    wait_results_drained();
    write_register(rsz_pkg::CfgSrcWidth, sw);
    write_register(rsz_pkg::CfgSrcHeight, sh);
    write_register(rsz_pkg::CfgDstWidth, dw);
    write_register(rsz_pkg::CfgDstHeight, dh);
  endtask

  // Directed: pixel extremes, corners, out-of-range requests and ignored loads.
  task automatic test_directed();
    set_sizes(4, 3, 7, 5);
    send_item(rsz_pkg::ActLoad, 0, 0, 24'h000000);
    send_item(rsz_pkg::ActLoad, 3, 2, 24'hFFFFFF);
    send_item(rsz_pkg::ActLoad, 4095, 4095, 24'hFFFFFF);
    send_item(rsz_pkg::ActLoad, 256, 0, 24'h123456);
    send_item(rsz_pkg::ActLoad, 0, 256, 24'h654321);
    send_request(0, 0);
    send_request(6, 4);
    send_request(3, 2);
    send_request(7, 0);
    send_request(0, 5);
    send_request(4095, 4095);
    // Zero source sizes, read as one, and a destination of one give a one-pixel image: the ratio is zero.
    set_sizes(0, 0, 1, 1);
    send_request(0, 0);
    send_request(1, 0);
    // Sizes beyond the limits saturate.
    set_sizes(300, 32'hFFFF_FFFF, 32'h1FFF, 4096);
    send_request(4095, 4095);
    send_request(0, 4095);
    send_request(2048, 17);
    set_sizes(256, 256, 2, 2);
    send_request(1, 1);
    send_request(0, 1);
  endtask

  // One random phase: random sizes, then mostly requests with loads mixed in.
  task automatic random_phase(int items);
    int k, sel;
    logic [CoordW-1:0] x, y;
    sel = $urandom_range(9);
    if (sel == 0)
      set_sizes(256, 256, $urandom_range(4096, 1), $urandom_range(4096, 1));
    else if (sel == 1)
      set_sizes($urandom, $urandom, $urandom, $urandom);
    else
      set_sizes($urandom_range(16, 1), $urandom_range(16, 1),
                $urandom_range(40, 1), $urandom_range(40, 1));
    for (k = 0; k < items; k++) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        send_request($urandom_range(dst_w - 1), $urandom_range(dst_h - 1));
      end else if (sel < 75) begin
        send_request($urandom, $urandom);
      end else if (sel < 92) begin
        send_item(rsz_pkg::ActLoad, $urandom_range(src_w - 1), $urandom_range(src_h - 1),
                  $urandom);
      end else begin
        x = $urandom;
        y = $urandom;
        send_item(rsz_pkg::ActLoad, x, y, $urandom);
      end
    end
  endtask

  task automatic test_random();
    int mode, p;
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 70 : 0;
      recv_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 0;
      for (p = 0; p < 5; p++) random_phase(50);
    end
  endtask

  // Result channel held off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sizes(8, 8, 20, 20);
    hold_len = 400;
    hold_token++;
    for (k = 0; k < 40; k++) send_request($urandom_range(19), $urandom_range(19));
    // Sender pauses until every result is back, then resumes.
    wait_results_drained();
    for (k = 0; k < 20; k++) send_request($urandom_range(19), $urandom_range(19));
  endtask

  // Result ready: random idling, or a long hold-off counted here.
  int hold_seen, hold_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= hold_len;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transaction with the oldest expected pixel.
  always @(posedge clk_i) begin : check_results
    resized_pixel_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      n_results++;
      if (expected_pixels.size() == 0) begin
        $error("result transaction with nothing expected: x=%0d y=%0d", rsp.out_x, rsp.out_y);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (rsp.out_x !== want.out_x) begin
          $error("out_x expected %0d actual %0d", want.out_x, rsp.out_x);
          errors++;
        end
        if (rsp.out_y !== want.out_y) begin
          $error("out_y expected %0d actual %0d", want.out_y, rsp.out_y);
          errors++;
        end
        if (rsp.pixel_out !== want.pixel_out) begin
          $error("pixel_out expected %06h actual %06h", want.pixel_out, rsp.pixel_out);
          errors++;
        end
        if (rsp.in_range !== want.in_range) begin
          $error("in_range expected %0b actual %0b", want.in_range, rsp.in_range);
          errors++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #4ms;
    $display("bilinear_image_resize_unit: mismatch");
    $finish;
  end

  initial begin
    req.valid    = 1'b0;
    req.action   = rsz_pkg::ActLoad;
    req.coord_x  = '0;
    req.coord_y  = '0;
    req.pixel_in = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    hold_token = 0;
    hold_len = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    src_w = rsz_pkg::SrcRst;
    src_h = rsz_pkg::SrcRst;
    dst_w = rsz_pkg::DstRst;
    dst_h = rsz_pkg::DstRst;
    scale_x = scale_ratio(src_w, dst_w);
    scale_y = scale_ratio(src_h, dst_h);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();
    test_backpressure();

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d loads, %0d requests, %0d results and %0d register writes",
             n_loads, n_requests, n_results, n_reg_writes);
    $display("across upscale, downscale, saturated and degenerate sizes with back-pressure.");
    if (errors == 0 && expected_pixels.size() == 0)
      $display("bilinear_image_resize_unit: match");
    else
      $display("bilinear_image_resize_unit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
